// File: rtl/bnsc_pkg.sv
// bnsc_pkg: shared constants, codes and types for the bitmap nth-set-bit cursor
// used by bnsc_store, bnsc_scan_unit and the bitmap_nth_set_bit_cursor top level
// no dependencies
`default_nettype none

package bnsc_pkg;

    localparam int BITMAP_BYTES = 8192;
    localparam int ADDR_W       = $clog2(BITMAP_BYTES);
    localparam int POS_W        = 16;
    localparam int CNT_W        = 17;

    // scan never looks at or beyond this position
    localparam logic [CNT_W-1:0] SCAN_CAP = (BITMAP_BYTES * 8 > 65536) ?
        CNT_W'(65536) : CNT_W'(BITMAP_BYTES * 8);

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic CFG_TOTAL_HITS  = 1'b0;
    localparam logic CFG_BITMAP_BITS = 1'b1;

    typedef enum logic [2:0] {
        STAT_DONE     = 3'd0,
        STAT_COUNT    = 3'd1,
        STAT_POS      = 3'd2,
        STAT_PAST     = 3'd3,
        STAT_BAD      = 3'd4,
        STAT_NOTFOUND = 3'd5
    } status_t;

    typedef struct packed {
        logic       fwd;
        logic       first;
        logic [2:0] off;
    } scan_ctl_t;

    typedef struct packed {
        logic [3:0]       cnt;
        logic             found;
        logic             last;
        logic [2:0]       sel;
        logic [CNT_W-1:0] rem_left;
    } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/bitmap_nth_set_bit_cursor.sv
// write, restart, count, past-end, bad-ordinal, cursor-hit and spare-kind transactions
// give their result in the cycle after acceptance, one transaction per cycle while busy is low
// scan queries: a setup state reads the first byte, then the bitmap bytes walked (0 to 8192)
// pass one byte per cycle through the scan unit and memory read port
// reset: bitmap clearing pass with busy high; config writes still taken
// the receiver cannot stall: each result is shown for exactly one cycle on done
`default_nettype none

module bitmap_nth_set_bit_cursor (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 kind,
    input  wire logic [12:0]                byte_addr,
    input  wire logic [7:0]                 byte_data,
    input  wire logic [16:0]                ordinal,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [16:0]                cfg_data,
    output logic                            done,
    output logic [2:0]                      status,
    output logic [16:0]                     value
);
    import bnsc_pkg::*;

    // sequencer: idle, set up the first byte, then one byte per cycle
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_START = 3'b010,
        S_EVAL  = 3'b100
    } state_t;

    state_t            state_reg, state_next;

    // configuration
    logic [CNT_W-1:0]  total_hits_reg;
    logic [CNT_W-1:0]  bitmap_bits_reg;

    // cursor: last answered hit number and its position
    logic [CNT_W-1:0]  cursor_hit_reg, cursor_hit_next;
    logic [POS_W-1:0]  cursor_pos_reg, cursor_pos_next;

    // scan context
    logic [CNT_W-1:0]  want_reg, want_next;
    logic              fwd_reg, fwd_next;
    logic              first_reg, first_next;
    logic [2:0]        off_reg, off_next;
    logic [ADDR_W-1:0] byte_reg, byte_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    // result register
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  value_reg, value_next;

    // memory port
    logic              mem_we;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              clearing;

    // scan unit
    scan_ctl_t         ctl;
    scan_res_t         res;

    logic              accept;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W:0]    hits_p1;
    logic [CNT_W-1:0]  fwd_p0;
    logic [CNT_W-1:0]  bwd_pos;
    logic [CNT_W-1:0]  bwd_pm1;
    logic              scan_empty;
    logic [ADDR_W-1:0] first_byte;
    logic [2:0]        first_off;
    logic [ADDR_W-1:0] step_byte;

    assign busy    = clearing || (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign lim     = (bitmap_bits_reg > SCAN_CAP) ? SCAN_CAP : bitmap_bits_reg;
    assign hits_p1 = {1'b0, total_hits_reg} + (CNT_W+1)'(1);

    // forward scan starts just past the cursor, or at position zero when clear
    assign fwd_p0  = (cursor_hit_reg == '0) ? '0 :
                     CNT_W'(cursor_pos_reg) + CNT_W'(1);
    // backward scan starts just below the cursor, clipped to the limit
    assign bwd_pos = (CNT_W'(cursor_pos_reg) > lim) ? lim : CNT_W'(cursor_pos_reg);
    assign bwd_pm1 = bwd_pos - CNT_W'(1);

    assign scan_empty = fwd_reg ? (fwd_p0 >= lim) : (bwd_pos == '0);
    assign first_byte = fwd_reg ? fwd_p0[POS_W-1:3] : bwd_pm1[POS_W-1:3];
    assign first_off  = fwd_reg ? fwd_p0[2:0] : bwd_pm1[2:0];
    assign step_byte  = fwd_reg ? byte_reg + ADDR_W'(1) : byte_reg - ADDR_W'(1);

    // read the first byte in setup, then prefetch the next one while evaluating
    assign rd_en   = (state_reg == S_START) || (state_reg == S_EVAL);
    assign rd_addr = (state_reg == S_START) ? first_byte : step_byte;

    assign ctl.fwd   = fwd_reg;
    assign ctl.first = first_reg;
    assign ctl.off   = off_reg;

    bnsc_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mem_we),
        .wr_addr  (byte_addr),
        .wr_data  (byte_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    bnsc_scan_unit u_scan (
        .data     (rd_data),
        .ctl      (ctl),
        .byte_idx (byte_reg),
        .lim      (lim),
        .rem      (rem_reg),
        .res      (res)
    );

    always_comb
    begin
        state_next      = state_reg;
        cursor_hit_next = cursor_hit_reg;
        cursor_pos_next = cursor_pos_reg;
        want_next       = want_reg;
        fwd_next        = fwd_reg;
        first_next      = first_reg;
        off_next        = off_reg;
        byte_next       = byte_reg;
        rem_next        = rem_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        value_next      = value_reg;
        mem_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_DONE;
                    value_next  = '0;
                    case (kind)
                        KIND_WRITE:
                        begin
                            // out-of-range addresses are dropped
                            mem_we = 32'(byte_addr) < BITMAP_BYTES;
                        end
                        KIND_RESTART:
                        begin
                            cursor_hit_next = '0;
                            cursor_pos_next = '0;
                        end
                        KIND_QUERY:
                        begin
                            if ({1'b0, ordinal} > hits_p1)
                            begin
                                status_next = STAT_BAD;
                            end
                            else if (ordinal == '0)
                            begin
                                status_next = STAT_COUNT;
                                value_next  = total_hits_reg;
                            end
                            else if (ordinal > total_hits_reg)
                            begin
                                status_next = STAT_PAST;
                            end
                            else if ((cursor_hit_reg != '0) && (cursor_hit_reg == ordinal))
                            begin
                                // repeat of the last answer, no scan
                                status_next = STAT_POS;
                                value_next  = CNT_W'(cursor_pos_reg);
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                want_next  = ordinal;
                                fwd_next   = ordinal > cursor_hit_reg;
                                state_next = S_START;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_START:
            begin
                if (scan_empty)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NOTFOUND;
                    value_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    byte_next  = first_byte;
                    off_next   = first_off;
                    first_next = 1'b1;
                    // hits still to pass, counted from the cursor
                    rem_next   = fwd_reg ? want_reg - cursor_hit_reg
                                         : cursor_hit_reg - want_reg;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (res.found)
                begin
                    done_next       = 1'b1;
                    status_next     = STAT_POS;
                    value_next      = {1'b0, byte_reg, res.sel};
                    cursor_hit_next = want_reg;
                    cursor_pos_next = {byte_reg, res.sel};
                    state_next      = S_IDLE;
                end
                else if (res.last)
                begin
                    // bitmap ran out before the hit, cursor kept
                    done_next   = 1'b1;
                    status_next = STAT_NOTFOUND;
                    value_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rem_next   = res.rem_left;
                    byte_next  = step_byte;
                    first_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cursor_hit_reg <= '0;
            cursor_pos_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_hit_reg <= cursor_hit_next;
            cursor_pos_reg <= cursor_pos_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg   <= want_next;
        fwd_reg    <= fwd_next;
        first_reg  <= first_next;
        off_reg    <= off_next;
        byte_reg   <= byte_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_hits_reg  <= '0;
            bitmap_bits_reg <= CNT_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOTAL_HITS:  total_hits_reg  <= cfg_data;
                CFG_BITMAP_BITS: bitmap_bits_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign value  = value_reg;

`ifndef SYNTH
    // a result only follows an accepted transaction or the end of a scan
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(accept) || $past(state_reg == S_START) ||
                      $past(state_reg == S_EVAL)))
        else $error("result without a transaction behind it");

    // a scan step that neither finds nor ends gives no result
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && !res.found && !res.last) |=> !done_reg)
        else $error("result during an unfinished scan");

    // a successful scan moves the cursor to the asked hit
    a_cursor_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && res.found) |=> (cursor_hit_reg == $past(want_reg)))
        else $error("cursor not moved after a hit");

    // a clear cursor always sits at position zero
    a_cursor_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_hit_reg == '0) |-> (cursor_pos_reg == '0))
        else $error("clear cursor with a stale position");
`endif

endmodule

`default_nettype wire

// File: rtl/bnsc_store.sv
// bnsc_store: bitmap byte memory, one write and one registered read port
// runs a clearing pass after reset; depends on bnsc_pkg
`default_nettype none

module bnsc_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [bnsc_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [bnsc_pkg::ADDR_W-1:0] rd_addr,
    output logic      [7:0]                  rd_data,
    output logic                             clearing
);
    import bnsc_pkg::*;

    logic [7:0]        mem [BITMAP_BYTES];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clearing_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    assign clr_addr_next = clr_addr_reg + ADDR_W'(1);
    assign mem_we        = clearing_reg || wr_en;
    assign mem_waddr     = clearing_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata     = clearing_reg ? 8'h00 : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_next;
            if (clr_addr_reg == ADDR_W'(BITMAP_BYTES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

// File: rtl/bnsc_scan_unit.sv
// bnsc_scan_unit: per-byte scan step, masks the live bits, counts them and
// picks the wanted hit inside the byte; depends on bnsc_pkg
`default_nettype none

module bnsc_scan_unit (
    input  wire logic [7:0]                  data,
    input  wire bnsc_pkg::scan_ctl_t         ctl,
    input  wire logic [bnsc_pkg::ADDR_W-1:0] byte_idx,
    input  wire logic [bnsc_pkg::CNT_W-1:0]  lim,
    input  wire logic [bnsc_pkg::CNT_W-1:0]  rem,
    output bnsc_pkg::scan_res_t              res
);
    import bnsc_pkg::*;

    logic [7:0]        pb;
    logic [7:0]        mask;
    logic [7:0]        m;
    logic [ADDR_W:0]   byte_ext;
    logic [ADDR_W:0]   lim_byte;
    logic [2:0]        lim_off;
    logic [CNT_W-1:0]  next_start;
    logic [3:0]        cnt;
    logic [3:0]        acc;
    logic [2:0]        sel;

    assign byte_ext   = {1'b0, byte_idx};
    assign lim_byte   = lim[CNT_W-1:3];
    assign lim_off    = lim[2:0];
    assign next_start = {byte_ext + (ADDR_W+1)'(1), 3'b000};

    always_comb
    begin
        int q;
        // position order: lowest position is the byte's top bit
        for (int i = 0; i < 8; i++)
        begin
            pb[i] = data[7 - i];
            if (ctl.fwd)
            begin
                mask[i] = (!ctl.first || (3'(i) >= ctl.off)) &&
                          ((byte_ext < lim_byte) ||
                           ((byte_ext == lim_byte) && (3'(i) < lim_off)));
            end
            else
            begin
                mask[i] = !ctl.first || (3'(i) <= ctl.off);
            end
        end
        m   = pb & mask;
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + 4'(m[i]);
        end
        // kth hit from the scan's side of the byte
        acc = '0;
        sel = '0;
        for (int i = 0; i < 8; i++)
        begin
            q = ctl.fwd ? i : 7 - i;
            if (m[q])
            begin
                acc = acc + 4'd1;
                if (acc == rem[3:0])
                begin
                    sel = 3'(q);
                end
            end
        end
    end

    assign res.cnt      = cnt;
    assign res.found    = CNT_W'(cnt) >= rem;
    assign res.rem_left = rem - CNT_W'(cnt);
    assign res.sel      = sel;
    assign res.last     = ctl.fwd ? (next_start >= lim) : (byte_idx == '0);

endmodule

`default_nettype wire

// File: dv/bnsc_result_checker.sv
// bnsc_result_checker: watches the command, config and result ports of the bitmap
// nth-set-bit cursor, predicts each result and compares it, field by field
// depends on bnsc_pkg for the kind, config index and status codes
`timescale 1ns / 1ps

module bnsc_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [12:0] byte_addr,
    input  logic [7:0]  byte_data,
    input  logic [16:0] ordinal,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [16:0] value,
    output int          fail_count,
    output int          open_count
);
    import bnsc_pkg::*;

    typedef struct packed {
        status_t     code;
        logic [16:0] amount;
    } answer_t;

    answer_t     answers [$];
    logic [7:0]  hit_bytes [BITMAP_BYTES];
    int unsigned hits_reg;
    int unsigned bits_reg;
    int unsigned cur_hit;
    int unsigned cur_pos;
    int          misses;

    function automatic bit hit_at(input int unsigned pos);
        logic [7:0] b;
        b = hit_bytes[pos >> 3];
        return b[7 - (pos % 8)];
    endfunction

    // walk from the cursor toward the wanted hit number
    function automatic bit seek_hit(input int unsigned want, output int unsigned where);
        int unsigned lim;
        int unsigned hcur;
        int unsigned pos;
        lim = bits_reg;
        if (lim > BITMAP_BYTES * 8)
        begin
            lim = BITMAP_BYTES * 8;
        end
        if (lim > 65536)
        begin
            lim = 65536;
        end
        hcur = cur_hit;
        where = 0;
        if (want > hcur)
        begin
            pos = (hcur == 0) ? 0 : cur_pos + 1;
            while (pos < lim)
            begin
                if (hit_at(pos))
                begin
                    hcur++;
                    if (hcur == want)
                    begin
                        where = pos;
                        return 1'b1;
                    end
                end
                pos++;
            end
        end
        else
        begin
            pos = (cur_pos > lim) ? lim : cur_pos;
            while (pos > 0)
            begin
                pos--;
                if (hit_at(pos))
                begin
                    hcur--;
                    if (hcur == want)
                    begin
                        where = pos;
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t     got_exp;
        answer_t     next_exp;
        int unsigned nord;
        int unsigned spot;
        if (!rst_n)
        begin
            foreach (hit_bytes[i])
            begin
                hit_bytes[i] = '0;
            end
            answers.delete();
            cur_hit = 0;
            cur_pos = 0;
            hits_reg = 0;
            bits_reg = 65536;
            misses = 0;
            fail_count <= 0;
            open_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (answers.size() == 0)
                begin
                    $display("%0t: result with nothing expected, status %0d value %0d",
                             $time, status, value);
                    misses++;
                end
                else
                begin
                    got_exp = answers.pop_front();
                    if (status !== got_exp.code)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, got_exp.code, status);
                        misses++;
                    end
                    if (value !== got_exp.amount)
                    begin
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, got_exp.amount, value);
                        misses++;
                    end
                end
            end

            if (start && !busy)
            begin
                next_exp.code = STAT_DONE;
                next_exp.amount = '0;
                nord = ordinal;
                case (kind)
                    KIND_WRITE:
                    begin
                        hit_bytes[byte_addr] = byte_data;
                    end
                    KIND_RESTART:
                    begin
                        cur_hit = 0;
                        cur_pos = 0;
                    end
                    KIND_QUERY:
                    begin
                        if (nord > hits_reg + 1)
                        begin
                            next_exp.code = STAT_BAD;
                        end
                        else if (nord == 0)
                        begin
                            next_exp.code = STAT_COUNT;
                            next_exp.amount = hits_reg[16:0];
                        end
                        else if (nord > hits_reg)
                        begin
                            next_exp.code = STAT_PAST;
                        end
                        else if (cur_hit != 0 && cur_hit == nord)
                        begin
                            next_exp.code = STAT_POS;
                            next_exp.amount = cur_pos[16:0];
                        end
                        else if (seek_hit(nord, spot))
                        begin
                            cur_hit = nord;
                            cur_pos = spot & 32'hFFFF;
                            next_exp.code = STAT_POS;
                            next_exp.amount = spot[16:0];
                        end
                        else
                        begin
                            next_exp.code = STAT_NOTFOUND;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                answers.push_back(next_exp);
            end

            // a register write lands after any transaction taken at the same edge
            if (cfg_we)
            begin
                if (cfg_index == CFG_TOTAL_HITS)
                begin
                    hits_reg = cfg_data;
                end
                else
                begin
                    bits_reg = cfg_data;
                end
            end

            fail_count <= misses;
            open_count <= answers.size();
        end
    end

endmodule

// File: dv/bitmap_nth_set_bit_cursor_test.sv
// bitmap_nth_set_bit_cursor_test: stimulus and verdict for the bitmap nth-set-bit cursor
// depends on bnsc_pkg, the bitmap_nth_set_bit_cursor block and bnsc_result_checker
`timescale 1ns / 1ps

module bitmap_nth_set_bit_cursor_test;
    import bnsc_pkg::*;

    localparam int CLK_PERIOD = 12;
    // kind code the block leaves unused, it must answer with a plain done
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [12:0] byte_addr;
    logic [7:0]  byte_data;
    logic [16:0] ordinal;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;
    logic        done;
    logic [2:0]  status;
    logic [16:0] value;
    int          fail_count;
    int          open_count;

    // copy of what the stimulus has loaded, only used to pick register settings
    logic [7:0]  loaded [BITMAP_BYTES];
    int unsigned hits_now;
    // last ordinal asked for, so most queries stay close to the cursor
    int unsigned last_ord;
    // when set, the sender adds no random idle time between transactions
    bit          steady;

    bitmap_nth_set_bit_cursor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .byte_addr (byte_addr),
        .byte_data (byte_data),
        .ordinal   (ordinal),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .status    (status),
        .value     (value)
    );

    bnsc_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .byte_addr  (byte_addr),
        .byte_data  (byte_data),
        .ordinal    (ordinal),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .value      (value),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop, several times the slowest expected run including long scans
    initial
    begin
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

    // present one transaction and hold it until the block takes it
    // start stays high afterwards so a following transaction goes back to back
    task automatic issue(input logic [1:0] k, input logic [12:0] a, input logic [7:0] d,
                         input logic [16:0] o);
        start <= 1'b1;
        kind <= k;
        byte_addr <= a;
        byte_data <= d;
        ordinal <= o;
        do @(posedge clk); while (busy);
        if (k == KIND_WRITE)
        begin
            loaded[a] = d;
        end
        if (k == KIND_RESTART)
        begin
            last_ord = 0;
        end
    endtask

    // query with random filler in the fields the block does not look at
    task automatic query(input int unsigned o);
        issue(KIND_QUERY, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)), 17'(o));
        if (o >= 1 && o <= hits_now)
        begin
            last_ord = o;
        end
    endtask

    // random idle time between transactions, mostly none or short, now and then long
    task automatic hold_off();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
        begin
            n = 0;
        end
        else if (r < 92)
        begin
            n = $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            n = $urandom_range(4, 12);
        end
        else
        begin
            n = $urandom_range(20, 60);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop sending until every outstanding transaction has its result back
    // the first edge lets the checker count a transaction taken this cycle
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (open_count != 0);
        repeat (4) @(posedge clk);
    endtask

    // both registers, only while the block is idle
    task automatic set_registers(input int unsigned hits, input int unsigned bits);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TOTAL_HITS;
        cfg_data <= 17'(hits);
        @(posedge clk);
        cfg_index <= CFG_BITMAP_BITS;
        cfg_data <= 17'(bits);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        hits_now = hits;
    endtask

    function automatic int unsigned ones_below(input int unsigned lim);
        int unsigned n;
        logic [7:0]  b;
        n = 0;
        for (int unsigned p = 0; p < lim; p++)
        begin
            b = loaded[p >> 3];
            n += b[7 - (p % 8)];
        end
        return n;
    endfunction

    // large bitmaps keep their data in two clusters at the ends so most scans stay short
    function automatic logic [12:0] pick_addr(input int unsigned nbytes, input bit wide);
        if (!wide)
        begin
            return 13'($urandom_range(0, nbytes - 1));
        end
        if ($urandom_range(0, 1) == 0)
        begin
            return 13'($urandom_range(0, 63));
        end
        return 13'($urandom_range(nbytes - 64, nbytes - 1));
    endfunction

    task automatic random_item(input int unsigned nbytes, input bit wide);
        int          r;
        int unsigned o;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            // neighbor of the last answer: one back, same, one or two ahead
            o = last_ord + $urandom_range(0, 3);
            o = (o > 1) ? o - 1 : 1;
            query(o);
        end
        else if (r < 67)
        begin
            query($urandom_range(1, hits_now + 1));
        end
        else if (r < 72)
        begin
            query(0);
        end
        else if (r < 76)
        begin
            query($urandom_range(hits_now + 2, 17'h1FFFF));
        end
        else if (r < 82)
        begin
            issue(KIND_RESTART, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
                  17'($urandom_range(0, 17'h1FFFF)));
        end
        else if (r < 90)
        begin
            issue(KIND_WRITE, pick_addr(nbytes, wide), 8'($urandom_range(0, 255)),
                  17'($urandom_range(0, 17'h1FFFF)));
        end
        else if (r < 93)
        begin
            issue(KIND_SPARE, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
                  17'($urandom_range(0, 17'h1FFFF)));
        end
        else
        begin
            // same ordinal again, normally answered from the cursor
            query((last_ord == 0) ? 1 : last_ord);
        end
    endtask

    // one setting of the registers: load part of the bitmap, program, then query it
    task automatic run_set(input int unsigned bits, input int count);
        int unsigned nbytes;
        int unsigned nfill;
        int unsigned total;
        int unsigned hits;
        int          style;
        int          r;
        bit          wide;
        logic [7:0]  d;
        logic [12:0] a;
        nbytes = (bits + 7) / 8;
        wide = (bits > 16384);
        nfill = (nbytes < 48) ? nbytes : 48;
        style = $urandom_range(0, 3);
        steady = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < nfill; i++)
        begin
            case (style)
                0: d = 8'($urandom & $urandom & $urandom);
                1: d = 8'($urandom);
                2: d = 8'hFF;
                default: d = 8'($urandom | $urandom);
            endcase
            a = (nbytes <= 48) ? 13'(i) : pick_addr(nbytes, wide);
            issue(KIND_WRITE, a, d, 17'($urandom_range(0, 17'h1FFFF)));
            hold_off();
        end
        drain();

        // mostly the true count, sometimes too high (lost hits) or too low
        total = ones_below(bits);
        r = $urandom_range(0, 9);
        if (!wide && r < 2)
        begin
            hits = total + $urandom_range(1, 3);
        end
        else if (r < 3 && total > 2)
        begin
            hits = total - $urandom_range(1, 2);
        end
        else
        begin
            hits = total;
        end
        if (hits > 65536)
        begin
            hits = 65536;
        end
        set_registers(hits, bits);

        issue(KIND_RESTART, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
              17'($urandom_range(0, 17'h1FFFF)));
        hold_off();
        for (int i = 0; i < count; i++)
        begin
            // now and then the sender waits for all results before going on
            if ($urandom_range(0, 99) < 3)
            begin
                drain();
            end
            random_item(nbytes, wide);
            hold_off();
        end
        drain();
    endtask

    initial
    begin
        int unsigned bits;
        rst_n <= 1'b0;
        start <= 1'b0;
        kind <= KIND_WRITE;
        byte_addr <= '0;
        byte_data <= '0;
        ordinal <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_TOTAL_HITS;
        cfg_data <= '0;
        foreach (loaded[i])
        begin
            loaded[i] = '0;
        end
        hits_now = 0;
        last_ord = 0;
        steady = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // block clears its bitmap after reset with busy high
        while (busy) @(posedge clk);

        // directed: first and last positions, an empty byte, default full range
        issue(KIND_WRITE, 13'd0, 8'h80, 17'h1FFFF);
        issue(KIND_WRITE, 13'd1, 8'h01, 17'h0);
        issue(KIND_WRITE, 13'd8191, 8'hFF, 17'h0);
        issue(KIND_WRITE, 13'd100, 8'h00, 17'h1FFFF);
        drain();
        set_registers(10, 65536);
        query(0);
        query(1);
        query(1);
        query(2);
        // forward walk across the whole bitmap to the very last position
        query(10);
        // backward walk from the cursor
        query(3);
        query(11);
        query(17'h1FFFF);
        issue(KIND_RESTART, 13'h1FFF, 8'hFF, 17'h1FFFF);
        query(3);
        issue(KIND_SPARE, 13'h1FFF, 8'hFF, 17'h1FFFF);
        // count now overstates the bitmap, so the scan runs out
        issue(KIND_WRITE, 13'd8191, 8'h00, 17'h0);
        query(10);
        query(2);
        issue(KIND_WRITE, 13'd8191, 8'hFF, 17'h0);
        drain();
        // register extremes: largest count with a one-bit range
        set_registers(65536, 1);
        query(1);
        query(2);
        query(65536);
        query(65537);
        query(0);
        drain();
        // empty count
        set_registers(0, 65536);
        query(0);
        query(1);
        query(2);
        drain();

        // random phases, mostly small ranges and a couple of large ones
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: bits = 1;
                1: bits = 8;
                2: bits = $urandom_range(9, 64);
                3: bits = $urandom_range(65, 512);
                4: bits = $urandom_range(513, 2048);
                5: bits = 65536;
                6: bits = 2048;
                7: bits = $urandom_range(1, 2048);
                8: bits = $urandom_range(9, 300);
                default: bits = $urandom_range(2049, 16384);
            endcase
            run_set(bits, 80);
        end

        start <= 1'b0;
        do @(posedge clk); while (open_count != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/bnsc_pkg.sv
rtl/bnsc_store.sv
rtl/bnsc_scan_unit.sv
rtl/bitmap_nth_set_bit_cursor.sv
dv/bnsc_result_checker.sv
dv/bitmap_nth_set_bit_cursor_test.sv
